### src/mlfd_pkg.sv
package mlfd_pkg;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned MagicW  = 24;
  localparam int unsigned LenW    = 16;
  localparam int unsigned PosW    = 17;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = MagicW;

  // Header layout: three magic bytes, the type byte, two length bytes.
  localparam logic [PosW-1:0] PosMagic0 = PosW'(0);
  localparam logic [PosW-1:0] PosMagic1 = PosW'(1);
  localparam logic [PosW-1:0] PosMagic2 = PosW'(2);
  localparam logic [PosW-1:0] PosType   = PosW'(3);
  localparam logic [PosW-1:0] PosLenHi  = PosW'(4);
  localparam logic [PosW-1:0] PosLenLo  = PosW'(5);
  localparam logic [PosW-1:0] HdrBytes  = PosW'(6);

  // Highest byte position a frame can reach (header plus maximum payload, minus one).
  localparam logic [PosW-1:0] PosMax = PosW'(65540);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMagicWord = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTypeLimit = CfgIdxW'(1);

  // Configuration reset values.
  localparam logic [MagicW-1:0] MagicReset     = '0;
  localparam logic [ByteW-1:0]  TypeLimitReset = 8'hff;

  // Per-byte status codes.
  typedef enum logic [1:0] {
    STATUS_HEADER  = 2'd0,
    STATUS_PAYLOAD = 2'd1,
    STATUS_LAST    = 2'd2,
    STATUS_DISCARD = 2'd3
  } status_e;

  // One result transaction.
  typedef struct packed {
    logic [LenW-1:0]  payload_index;
    logic [LenW-1:0]  frame_length;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] data_byte;
    status_e          status;
    logic             last;
  } result_t;

  // Output tdata width: status, data byte, type, length and index, padded to bytes.
  localparam int unsigned OutFieldW = 2 + ByteW + ByteW + LenW + LenW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

endpackage

### src/mlfd_parser.sv
module mlfd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic [mlfd_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [mlfd_pkg::MagicW-1:0]   magic_word_i,
  input  logic [mlfd_pkg::ByteW-1:0]    type_limit_i,
  output mlfd_pkg::result_t             result_o
);
  import mlfd_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] held_type_q, held_type_d;
  logic [LenW-1:0]  held_length_q, held_length_d;

  logic [PosW-1:0]  end_pos;
  logic [PosW-1:0]  idx_wide;
  logic             in_payload;
  status_e          status;

  assign end_pos    = {1'b0, held_length_q} + (HdrBytes - PosW'(1));
  assign in_payload = (pos_q >= HdrBytes);
  assign idx_wide   = pos_q - HdrBytes;

  // Classify the byte against the current frame position.
  always_comb begin
    status        = STATUS_DISCARD;
    held_type_d   = held_type_q;
    held_length_d = held_length_q;
    if ((pos_q == PosMagic0) && (rx_byte_i == magic_word_i[23:16])) begin
      status = STATUS_HEADER;
    end else if ((pos_q == PosMagic1) && (rx_byte_i == magic_word_i[15:8])) begin
      status = STATUS_HEADER;
    end else if ((pos_q == PosMagic2) && (rx_byte_i == magic_word_i[7:0])) begin
      status = STATUS_HEADER;
    end else if ((pos_q == PosType) && (rx_byte_i != '0) && (rx_byte_i < type_limit_i)) begin
      status      = STATUS_HEADER;
      held_type_d = rx_byte_i;
    end else if (pos_q == PosLenHi) begin
      status        = STATUS_HEADER;
      held_length_d = {rx_byte_i, 8'h00};
    end else if (pos_q == PosLenLo) begin
      status        = STATUS_HEADER;
      held_length_d = {held_length_q[15:8], rx_byte_i};
    end else if (in_payload && (pos_q < end_pos)) begin
      status = STATUS_PAYLOAD;
    end else if (in_payload && (pos_q == end_pos)) begin
      status = STATUS_LAST;
    end
  end

  // Build the result from the updated frame fields.
  always_comb begin
    result_o.status        = status;
    result_o.data_byte     = rx_byte_i;
    result_o.frame_type    = (status == STATUS_DISCARD) ? '0 : held_type_d;
    result_o.frame_length  = (status == STATUS_DISCARD) ? '0 : held_length_d;
    result_o.payload_index = ((status == STATUS_PAYLOAD) || (status == STATUS_LAST))
                             ? idx_wide[LenW-1:0] : '0;
    result_o.last          = (status == STATUS_LAST);
  end

  // A finished or broken frame returns the state to zero.
  always_comb begin
    if ((status == STATUS_LAST) || (status == STATUS_DISCARD)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      held_type_q   <= '0;
      held_length_q <= '0;
    end else if (advance_i) begin
      pos_q <= pos_d;
      if ((status == STATUS_LAST) || (status == STATUS_DISCARD)) begin
        held_type_q   <= '0;
        held_length_q <= '0;
      end else begin
        held_type_q   <= held_type_d;
        held_length_q <= held_length_d;
      end
    end
  end

`ifndef SYNTH
  // The position never runs past the end of the longest frame.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("frame position out of range");

  // No type is held before the type byte has been taken.
  a_type_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= PosType) |-> (held_type_q == '0))
    else $error("type held before type byte");

  // No length is held before the length bytes arrive.
  a_len_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q <= PosLenHi) |-> (held_length_q == '0))
    else $error("length held before length bytes");

  // A finished or discarded byte restarts the search for the magic.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && ((status == STATUS_LAST) || (status == STATUS_DISCARD)))
    |=> (pos_q == '0))
    else $error("frame state not cleared");
`endif

endmodule

### src/magic_length_frame_deframer_top.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] rx_byte
// m_axis   | out       | tdata: status, data_byte, frame_type, frame_length,
//          |           |   payload_index (low bits up, zero padded); tlast = last
// cfg      | in        | cfg_idx_i 0 magic_word, 1 type_limit; cfg_data_i 24 bits
//
// One byte is accepted per cycle unless m_axis stalls; it passes through the input
// register, and its result through the result register. The rate is set by the frame
// state update between the input register and the result register.
// Reset clears the frame state, sets magic_word to 0 and type_limit to 255.
// A stall on m_axis holds the result; the input register then fills and
// s_axis_tready drops until the result is taken.
module magic_length_frame_deframer_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream: rx_byte.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [mlfd_pkg::ByteW-1:0]            s_axis_tdata,
  // Output stream: status[1:0], data_byte[9:2], frame_type[17:10],
  // frame_length[33:18], payload_index[49:34], zero padding above.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [mlfd_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                  m_axis_tlast,
  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [mlfd_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [mlfd_pkg::CfgW-1:0]             cfg_data_i
);
  import mlfd_pkg::*;

  logic [MagicW-1:0] magic_word_q;
  logic [ByteW-1:0]  type_limit_q;

  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_valid_q;
  result_t           out_q;
  result_t           result;
  logic              advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q <= MagicReset;
      type_limit_q <= TypeLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMagicWord: magic_word_q <= cfg_data_i[MagicW-1:0];
        CfgTypeLimit: type_limit_q <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the parser advances when the result register can load.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  mlfd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .rx_byte_i    (in_byte_q),
    .magic_word_i (magic_word_q),
    .type_limit_i (type_limit_q),
    .result_o     (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {(OutDataW - OutFieldW)'(0), out_q.payload_index,
                          out_q.frame_length, out_q.frame_type, out_q.data_byte,
                          out_q.status};

endmodule
